// File: rtl/lzwcd_pkg.sv
package lzwcd_pkg;

  localparam int CODE_W           = 12;
  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 7;
  localparam int ROOT_COUNT       = 256;
  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int MAX_LEN_DEF      = 64;

  // one dictionary entry: chain link, last byte, first byte, string length
  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
    logic [BYTE_W-1:0] head;
    logic [LEN_W-1:0]  len;
  } dict_word_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOOKC  = 8'b0000_0010,
    S_LOOKP  = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_WSTART = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_ERR    = 8'b1000_0000
  } state_t;

endpackage

// File: rtl/lzwcd_ram.sv
module lzwcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lzw_code_decoder_unit.sv
// each accepted code is looked up together with the previous code (S_LOOKC, S_LOOKP),
//   checked (S_CHECK) and, if good, unwound (S_WSTART, S_WALK), then emitted (S_EMIT)
// the prefix chain is walked one dictionary RAM read per byte, then the byte stack RAM is
//   read out one byte per cycle while the output is not stalled; no new code is taken until then
// a code dropped while in the error state is taken without leaving S_IDLE; a bad code gives an error result
// reset: synchronous, clears control state and empties the dictionary to the roots
module lzw_code_decoder_unit
  import lzwcd_pkg::*;
#(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
  parameter int MAX_LEN      = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] code,
  input  logic              start_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] data_byte,
  output logic              last,
  output logic              error
);

  localparam int DA_W  = $clog2(DICT_ENTRIES);
  localparam int NF_W  = DA_W + 1;
  localparam int CMP_W = (NF_W > CODE_W) ? NF_W : CODE_W;
  localparam int SA_W  = $clog2(MAX_LEN);
  localparam int DWD_W = $bits(dict_word_t);

  state_t            state;
  logic [NF_W-1:0]   next_free;
  logic [CODE_W-1:0] prev_code;
  logic              have_prev;
  logic              failed;
  logic              prime;

  logic [CODE_W-1:0] code_r;
  dict_word_t        c_word;
  logic [CODE_W-1:0] walk;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  item_len;
  logic [SA_W-1:0]   rd_idx;

  // dictionary RAM
  logic              d_we;
  logic [DA_W-1:0]   d_waddr;
  dict_word_t        d_wdata;
  logic [DA_W-1:0]   d_raddr;
  logic [DWD_W-1:0]  d_rdata;
  dict_word_t        p_word;

  // byte stack RAM
  logic              s_we;
  logic [SA_W-1:0]   s_waddr;
  logic [BYTE_W-1:0] s_wdata;
  logic [SA_W-1:0]   s_raddr;
  logic [BYTE_W-1:0] s_rdata;

  logic [CMP_W-1:0]  c_ext;
  logic [CMP_W-1:0]  p_ext;
  logic [CMP_W-1:0]  nf_ext;
  logic [CMP_W-1:0]  pre_ext;
  logic              c_root;
  logic              p_root;
  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  len_p;
  logic [LEN_W-1:0]  len_new;
  logic [BYTE_W-1:0] head_c;
  logic [BYTE_W-1:0] head_p;
  logic              kw;
  logic [LEN_W-1:0]  len_sel;
  logic              bad;
  logic              grow;
  logic [LEN_W-1:0]  cnt_m1;
  logic              in_take;
  logic              out_free;
  logic              load;
  logic              err_load;
  logic              is_last;

  lzwcd_ram #(
    .WIDTH (DWD_W),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  lzwcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign p_word  = dict_word_t'(d_rdata);
  assign c_ext   = CMP_W'(code_r);
  assign p_ext   = CMP_W'(prev_code);
  assign nf_ext  = CMP_W'(next_free);
  assign pre_ext = CMP_W'(p_word.prefix);

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // roots are implicit: length one, head byte is the code itself
  assign c_root  = code_r < CODE_W'(ROOT_COUNT);
  assign p_root  = prev_code < CODE_W'(ROOT_COUNT);
  assign len_c   = c_root ? LEN_W'(1) : c_word.len;
  assign head_c  = c_root ? code_r[BYTE_W-1:0] : c_word.head;
  assign len_p   = p_root ? LEN_W'(1) : p_word.len;
  assign head_p  = p_root ? prev_code[BYTE_W-1:0] : p_word.head;
  assign len_new = len_p + LEN_W'(1);
  assign kw      = (c_ext == nf_ext);
  assign len_sel = !have_prev ? LEN_W'(1) : (kw ? len_new : len_c);

  always_comb begin
    if (!have_prev) begin
      bad = !c_root;
    end else begin
      bad = (c_ext >= CMP_W'(DICT_ENTRIES)) || (c_ext > nf_ext) ||
            (len_sel > LEN_W'(MAX_LEN)) || (len_sel == '0);
    end
  end

  assign grow = have_prev && !bad && (nf_ext < CMP_W'(DICT_ENTRIES));

  assign d_we           = (state == S_CHECK) && grow;
  assign d_waddr        = nf_ext[DA_W-1:0];
  assign d_wdata.prefix = prev_code;
  assign d_wdata.suffix = kw ? head_p : head_c;
  assign d_wdata.head   = head_p;
  assign d_wdata.len    = len_new;

  always_comb begin
    unique case (state)
      S_LOOKP: d_raddr = p_ext[DA_W-1:0];
      S_WALK:  d_raddr = pre_ext[DA_W-1:0];
      default: d_raddr = c_ext[DA_W-1:0];
    endcase
  end

  // the chain yields the last byte first, so bytes land in the stack back to front
  assign cnt_m1  = cnt - LEN_W'(1);
  assign s_we    = (state == S_WALK);
  assign s_waddr = cnt_m1[SA_W-1:0];
  assign s_wdata = (cnt > LEN_W'(1)) ? p_word.suffix : walk[BYTE_W-1:0];

  assign out_free = !out_valid || !out_stall;
  assign load     = (state == S_EMIT) && !prime && out_free;
  assign err_load = (state == S_ERR) && out_free;
  assign is_last  = (LEN_W'(rd_idx) + LEN_W'(1)) == item_len;
  // hold the read address until the byte is taken so the read data stays put
  assign s_raddr  = load ? rd_idx + SA_W'(1) : rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= NF_W'(ROOT_COUNT);
      prev_code <= '0;
      have_prev <= 1'b0;
      failed    <= 1'b0;
      prime     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (start_req) begin
              next_free <= NF_W'(ROOT_COUNT);
              have_prev <= 1'b0;
              failed    <= 1'b0;
            end
            if (!failed || start_req) begin
              state <= S_LOOKC;
            end
          end
        end
        S_LOOKC: state <= S_LOOKP;
        S_LOOKP: state <= S_CHECK;
        S_CHECK: begin
          if (bad) begin
            failed <= 1'b1;
            state  <= S_ERR;
          end else begin
            if (grow) begin
              next_free <= next_free + NF_W'(1);
            end
            prev_code <= code_r;
            have_prev <= 1'b1;
            state     <= S_WSTART;
          end
        end
        S_WSTART: state <= S_WALK;
        S_WALK: begin
          if (cnt <= LEN_W'(1)) begin
            prime <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          prime <= 1'b0;
          if (load && is_last) begin
            state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (err_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      code_r <= code;
    end
    if (state == S_LOOKP) begin
      c_word <= dict_word_t'(d_rdata);
    end
    if ((state == S_CHECK) && !bad) begin
      item_len <= len_sel;
      cnt      <= len_sel;
      walk     <= code_r;
    end
    if ((state == S_WALK) && (cnt > LEN_W'(1))) begin
      walk <= p_word.prefix;
      cnt  <= cnt_m1;
    end
    if ((state == S_WALK) && (cnt <= LEN_W'(1))) begin
      rd_idx <= '0;
    end else if (load) begin
      rd_idx <= rd_idx + SA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load || err_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte <= s_rdata;
      last      <= is_last;
      error     <= 1'b0;
    end else if (err_load) begin
      data_byte <= '0;
      last      <= 1'b1;
      error     <= 1'b1;
    end
  end

endmodule

// File: test/lzw_code_decoder_unit_check.sv
`timescale 1ns / 1ps
module lzw_code_decoder_unit_check
  import lzwcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CODE_W-1:0] code,
  input  logic              start_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last,
  input  logic              error,
  output int                fails,
  output int                waiting,
  output int                codes_seen,
  output int                bytes_seen,
  output int                errs_seen,
  output int                kwk_seen
);

  localparam int Q_DEPTH = 1024;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              fin;
    logic              bad;
  } byte_out_t;

  logic [CODE_W-1:0] link_tbl  [DICT_ENTRIES_DEF];
  logic [BYTE_W-1:0] tail_tbl  [DICT_ENTRIES_DEF];
  logic [BYTE_W-1:0] first_tbl [DICT_ENTRIES_DEF];
  logic [LEN_W-1:0]  size_tbl  [DICT_ENTRIES_DEF];
  int                free_idx;
  logic [CODE_W-1:0] last_code;
  logic              primed;
  logic              dead;
  // expected bytes in order, as a ring
  byte_out_t         decoded_q [Q_DEPTH];
  int                q_head;
  int                q_tail;

  function automatic int str_len(input int c);
    if (c < ROOT_COUNT) begin
      return 1;
    end
    return int'(size_tbl[c]);
  endfunction

  function automatic logic [BYTE_W-1:0] str_head(input int c);
    if (c < ROOT_COUNT) begin
      return c[BYTE_W-1:0];
    end
    return first_tbl[c];
  endfunction

  task automatic put_byte(input byte_out_t r);
    decoded_q[q_tail % Q_DEPTH] = r;
    q_tail++;
  endtask

  // stream is dead until the next start
  task automatic flag_error();
    byte_out_t r;
    r.value = '0;
    r.fin = 1'b1;
    r.bad = 1'b1;
    dead = 1'b1;
    put_byte(r);
  endtask

  task automatic decode_code(input int c, input logic s);
    int n;
    int i;
    int walk;
    logic [BYTE_W-1:0] stack [MAX_LEN_DEF];
    byte_out_t r;
    if (s) begin
      free_idx = ROOT_COUNT;
      primed = 1'b0;
      dead = 1'b0;
    end
    if (dead) begin
      return;
    end
    codes_seen++;
    if (!primed) begin
      if (c >= ROOT_COUNT) begin
        flag_error();
        return;
      end
      n = 1;
    end else begin
      if (c >= DICT_ENTRIES_DEF || c > free_idx) begin
        flag_error();
        return;
      end
      n = (c < free_idx) ? str_len(c) : str_len(int'(last_code)) + 1;
      if (n > MAX_LEN_DEF) begin
        flag_error();
        return;
      end
      if (c == free_idx) begin
        kwk_seen++;
      end
      if (free_idx < DICT_ENTRIES_DEF) begin
        link_tbl[free_idx]  = last_code;
        tail_tbl[free_idx]  = (c < free_idx) ? str_head(c) : str_head(int'(last_code));
        first_tbl[free_idx] = str_head(int'(last_code));
        size_tbl[free_idx]  = LEN_W'(str_len(int'(last_code)) + 1);
        free_idx++;
      end
    end
    // unwind the chain, last byte first
    walk = c;
    for (i = n; i > 1; i--) begin
      stack[i-1] = tail_tbl[walk];
      walk = int'(link_tbl[walk]);
    end
    stack[0] = walk[BYTE_W-1:0];
    for (i = 0; i < n; i++) begin
      r.value = stack[i];
      r.fin = (i == n - 1);
      r.bad = 1'b0;
      put_byte(r);
    end
    last_code = c[CODE_W-1:0];
    primed = 1'b1;
  endtask

  task automatic note_diff(input string field, input logic [BYTE_W-1:0] want,
                           input logic [BYTE_W-1:0] got);
    fails++;
    if (fails <= 30) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    end
  endtask

  task automatic check_byte();
    byte_out_t want;
    bytes_seen++;
    if (error === 1'b1) begin
      errs_seen++;
    end
    if (q_tail == q_head) begin
      fails++;
      if (fails <= 30) begin
        $display("%0t: byte %h last %b error %b with nothing expected", $time,
                 data_byte, last, error);
      end
      return;
    end
    want = decoded_q[q_head % Q_DEPTH];
    q_head++;
    if (data_byte !== want.value) begin
      note_diff("data_byte", want.value, data_byte);
    end
    if (last !== want.fin) begin
      note_diff("last", BYTE_W'(want.fin), BYTE_W'(last));
    end
    if (error !== want.bad) begin
      note_diff("error", BYTE_W'(want.bad), BYTE_W'(error));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      free_idx = ROOT_COUNT;
      last_code = '0;
      primed = 1'b0;
      dead = 1'b0;
      q_head = 0;
      q_tail = 0;
      fails = 0;
      codes_seen = 0;
      bytes_seen = 0;
      errs_seen = 0;
      kwk_seen = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_code(int'(code), start_req);
      end
      if (out_valid && !out_stall) begin
        check_byte();
      end
    end
    waiting <= q_tail - q_head;
  end

endmodule

// File: test/lzw_code_decoder_unit_test.sv
`timescale 1ns / 1ps
module lzw_code_decoder_unit_test;
  import lzwcd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 600;
  localparam int RANDOM_CODES = 70;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CODE_W-1:0] code;
  logic              start_req;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] data_byte;
  logic              last;
  logic              error;
  logic              hold_req;

  int fails;
  int waiting;
  int codes_seen;
  int bytes_seen;
  int errs_seen;
  int kwk_seen;
  int cycles;

  // rough view of the stream, only to steer stimulus
  int nxt;
  int prev;
  bit primed;
  bit dead;
  int taken;
  int burst_left;
  int len_of [DICT_ENTRIES_DEF];

  lzw_code_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code      (code),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_byte (data_byte),
    .last      (last),
    .error     (error)
  );

  lzw_code_decoder_unit_check chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code       (code),
    .start_req  (start_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .last       (last),
    .error      (error),
    .fails      (fails),
    .waiting    (waiting),
    .codes_seen (codes_seen),
    .bytes_seen (bytes_seen),
    .errs_seen  (errs_seen),
    .kwk_seen   (kwk_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lzw_code_decoder_unit: mismatch");
      $finish;
    end
  end

  // receiver: stall pattern changes every so often, one long hold on request
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
      end
    end
  end

  function automatic int len_of_code(input int c);
    return (c < ROOT_COUNT) ? 1 : len_of[c];
  endfunction

  function automatic void track_code(input int c, input bit s);
    int n;
    if (s) begin
      nxt = ROOT_COUNT;
      primed = 1'b0;
      dead = 1'b0;
    end
    if (dead) begin
      return;
    end
    taken++;
    if (!primed) begin
      if (c >= ROOT_COUNT) begin
        dead = 1'b1;
      end else begin
        primed = 1'b1;
        prev = c;
      end
      return;
    end
    if (c >= DICT_ENTRIES_DEF || c > nxt) begin
      dead = 1'b1;
      return;
    end
    n = (c < nxt) ? len_of_code(c) : len_of_code(prev) + 1;
    if (n > MAX_LEN_DEF) begin
      dead = 1'b1;
      return;
    end
    if (nxt < DICT_ENTRIES_DEF) begin
      len_of[nxt] = len_of_code(prev) + 1;
      nxt++;
    end
    prev = c;
  endfunction

  task automatic send_code(input int c, input bit s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    code <= c[CODE_W-1:0];
    start_req <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_code(c, s);
  endtask

  // sender pause until every byte has come out
  task automatic quiesce();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  function automatic int pick_code();
    int r;
    int reach;
    r = $urandom_range(0, 99);
    if (r < 20 && nxt < DICT_ENTRIES_DEF) begin
      return nxt;
    end
    if (r < 40 && nxt > ROOT_COUNT) begin
      reach = (nxt - ROOT_COUNT > 8) ? 7 : nxt - ROOT_COUNT - 1;
      return nxt - 1 - $urandom_range(0, reach);
    end
    if (r < 75) begin
      return $urandom_range(0, nxt - 1);
    end
    if (r < 95 || nxt >= DICT_ENTRIES_DEF - 1) begin
      return $urandom_range(0, ROOT_COUNT - 1);
    end
    return $urandom_range(nxt + 1, DICT_ENTRIES_DEF - 1);
  endfunction

  initial begin
    int goal;
    rst <= 1'b1;
    in_valid <= 1'b0;
    code <= '0;
    start_req <= 1'b0;
    hold_req <= 1'b0;
    nxt = ROOT_COUNT;
    prev = 0;
    primed = 1'b0;
    dead = 1'b0;
    taken = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // first code straight after reset, no start
    send_code('h041, 1'b0);
    send_code('h042, 1'b0);
    send_code(256, 1'b0);
    send_code(258, 1'b0);
    send_code('h0ff, 1'b0);
    send_code('h000, 1'b0);
    send_code(261, 1'b0);
    // beyond next index, then blocked codes
    send_code('hfff, 1'b0);
    send_code('h041, 1'b0);
    send_code('h100, 1'b0);
    send_code('h0ff, 1'b1);
    // first code must be a root
    send_code('h100, 1'b1);
    send_code('h042, 1'b0);
    send_code('h000, 1'b1);
    send_code(256, 1'b0);
    send_code(257, 1'b0);
    send_code('h800, 1'b0);
    send_code('hfff, 1'b1);
    send_code('h080, 1'b1);
    send_code('h000, 1'b0);
    send_code(257, 1'b0);
    quiesce();

    // self-referencing chain grows one byte per code until too long
    hold_req <= 1'b1;
    send_code($urandom_range(0, ROOT_COUNT - 1), 1'b1);
    repeat (MAX_LEN_DEF) send_code(nxt, 1'b0);
    send_code($urandom_range(0, ROOT_COUNT - 1), 1'b0);
    quiesce();

    // random streams with the odd bad first code and bad code
    goal = taken + RANDOM_CODES;
    while (taken < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_code($urandom_range(ROOT_COUNT, DICT_ENTRIES_DEF - 1), 1'b1);
      end else begin
        send_code($urandom_range(0, ROOT_COUNT - 1), 1'b1);
      end
      repeat ($urandom_range(2, 24)) begin
        if (dead) begin
          if ($urandom_range(0, 1) == 1) begin
            send_code($urandom_range(0, DICT_ENTRIES_DEF - 1), 1'b0);
          end
        end else begin
          send_code(pick_code(), 1'b0);
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        quiesce();
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d decoded codes (%0d self-referencing), %0d bytes, %0d error results",
             codes_seen, kwk_seen, bytes_seen, errs_seen);
    $display("chain grown past the length bound, output held off %0d cycles once",
             LONG_HOLD);
    if (fails == 0 && waiting == 0) begin
      $display("lzw_code_decoder_unit: match");
    end else begin
      $display("lzw_code_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
